### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files that check themselves.
// Every macro samples on the rising edge of i_clk and is quiet while
// i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("next-cycle assertion failed");

`endif

### hdl/sws_pkg.sv
`default_nettype none

package sws_pkg;

    // Width of the elapsed time that enters the divider.
    localparam int TIME_WIDTH = 32;
    // Fraction bits produced by the divider below the binary point.
    localparam int FRAC_BITS  = 16;
    localparam int PERIOD_W   = 32;
    localparam int VOLT_W     = 16;
    localparam int REPEAT_W   = 16;
    localparam int CFG_DATA_W = 32;
    localparam int QUO_W      = TIME_WIDTH + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(QUO_W);

    // Half a volt in Q8.8, held one bit wider than a voltage for differences.
    localparam logic signed [VOLT_W:0] HALF_VOLT = (VOLT_W + 1)'(128);

    typedef enum logic [1:0] {
        CFG_START  = 2'd0,
        CFG_END    = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_REPEAT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

`default_nettype wire

### hdl/sws_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is extended by
// FRAC_BITS zero bits, so the quotient carries the integer cycle number in
// its upper bits and the fraction of the cycle in its lower bits.
module sws_div
    import sws_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [TIME_WIDTH-1:0] i_dividend,
    input  wire logic [PERIOD_W-1:0]   i_divisor,
    output t_div_sts                   o_sts,
    output logic      [QUO_W-1:0]      o_quotient
);

    logic [PERIOD_W-1:0]  r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [PERIOD_W-1:0]  r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [PERIOD_W:0]    rem_sh;
    logic [PERIOD_W:0]    rem_sub;
    logic                 take;

    // Shift the next dividend bit into the partial remainder and try the
    // subtraction; the remainder always stays below the divisor.
    always_comb begin
        rem_sh  = {r_rem, r_quo[QUO_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        take    = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], take};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

### hdl/sawtooth_sweep_source.sv
// Sawtooth sweep voltage source with a burst count.
//
// Input stream (i_s_*): each word is one command. A begin word (tuser = 0)
// emits the start voltage and loads the previous-value register with it.
// A step word (tuser = 1) carries an elapsed time in ticks in tdata; the
// block divides it by the period into a cycle number and a 16-bit fraction
// and emits start + (end - start) * fraction, or 0 V with the expired flag
// once a nonzero repeat count has been reached. The step flag marks a change
// of more than 0.5 V against the previous output.
// Output stream (o_m_*): one word per input word, in order.
// Path: a begin word goes straight to the output stage. A step word passes
// the shift-subtract divider (one quotient bit per cycle), the capture of
// the quotient, a multiply, an add and the output stage; an expired step
// word skips the multiply and the add. The input is not ready while a word
// is being worked on, so a new word is taken only once the last one has
// left the output stage. A finished word sits in the output register; the
// next input word may be accepted while it waits, and a stalled receiver
// only holds the block in its output stage. Reset restores the register
// defaults and clears the previous voltage to 0 V. The user must write the
// registers only between words; the block itself does not enforce this.
`default_nettype none

`include "assert_macros.svh"

module sawtooth_sweep_source
    import sws_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream.
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [31:0]           i_s_tdata,   // [31:0] elapsed_time
    input  wire logic                  i_s_tuser,   // [0] cmd
    // Output stream.
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [15:0]                o_m_tdata,   // [15:0] voltage
    output logic [1:0]                 o_m_tuser,   // [0] step_flag, [1] expired
    // Configuration write port.
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic signed [VOLT_W-1:0]   r_start;
    logic signed [VOLT_W-1:0]   r_end;
    logic        [PERIOD_W-1:0] r_period;
    logic        [REPEAT_W-1:0] r_repeat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= VOLT_W'(0);
            r_end    <= VOLT_W'(1280);
            r_period <= PERIOD_W'(1000000);
            r_repeat <= REPEAT_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START:  r_start  <= i_cfg_data[VOLT_W-1:0];
                CFG_END:    r_end    <= i_cfg_data[VOLT_W-1:0];
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_REPEAT: r_repeat <= i_cfg_data[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    t_state                      r_state, n_state;
    logic signed [VOLT_W:0]      r_diff;
    logic        [FRAC_BITS-1:0] r_frac;
    logic signed [VOLT_W+FRAC_BITS+1:0] r_prod;
    logic signed [VOLT_W-1:0]    r_v;
    logic                        r_exp;
    logic signed [VOLT_W-1:0]    r_prev;
    logic                        r_out_valid;
    logic        [VOLT_W-1:0]    r_out_volt;
    logic                        r_out_flag;
    logic                        r_out_exp;

    logic                  in_acc;
    logic                  div_start;
    logic [PERIOD_W-1:0]   period_eff;
    t_div_sts              div_sts;
    logic [QUO_W-1:0]      div_quo;
    logic [TIME_WIDTH-1:0] cycle_num;
    logic                  is_expired;
    logic signed [VOLT_W:0] dv;
    logic                  step_flag;
    logic                  out_free;

    // A zero period behaves as a period of one tick.
    assign period_eff = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign div_start  = in_acc && i_s_tuser;

    sws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_s_tdata[TIME_WIDTH-1:0]),
        .i_divisor  (period_eff),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    // The whole integer quotient is compared, so a huge cycle number still
    // counts as past the burst.
    assign cycle_num  = div_quo[QUO_W-1:FRAC_BITS];
    assign is_expired = (r_repeat != '0) &&
                        (cycle_num >= TIME_WIDTH'(r_repeat));

    assign dv        = {r_v[VOLT_W-1], r_v} - {r_prev[VOLT_W-1], r_prev};
    assign step_flag = (dv > HALF_VOLT) || (dv < -HALF_VOLT);
    assign out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = i_s_tuser ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    n_state = is_expired ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: n_state = ST_SUM;
            ST_SUM: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath: the product is floored by selecting the bits above the fraction
    // bits, which rounds toward minus infinity. The result
    // always lies between start and end, so the low bits of the sum suffice.
    // The quotient is only looked at once the divider reports it finished.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_diff <= {r_end[VOLT_W-1], r_end} - {r_start[VOLT_W-1], r_start};
                r_v    <= r_start;
                r_exp  <= 1'b0;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    r_frac <= div_quo[FRAC_BITS-1:0];
                    if (is_expired) begin
                        r_v   <= '0;
                        r_exp <= 1'b1;
                    end
                end
            end
            ST_MUL: r_prod <= r_diff * $signed({1'b0, r_frac});
            ST_SUM: r_v    <= r_start + r_prod[FRAC_BITS+VOLT_W-1:FRAC_BITS];
            default: ;
        endcase
    end

    // Output register and previous voltage. A begin word reports no step
    // and is never expired; both flags stay low on that path.
    logic r_is_step;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_step <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_v;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_volt <= r_v;
            r_out_flag <= r_is_step && step_flag;
            r_out_exp  <= r_exp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_volt;
    assign o_m_tuser  = {r_out_exp, r_out_flag};

    // Checks on the sequencer and the datapath.
    `SWS_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_s_tready)
    `SWS_ASSERT_SAME(a_div_done_in_div, div_sts.done, r_state == ST_DIV)
    `SWS_ASSERT_SAME(a_expired_is_zero, o_m_tvalid && o_m_tuser[1], o_m_tdata == '0)
    `SWS_ASSERT_SAME(a_div_busy_in_div, div_sts.busy, r_state == ST_DIV)

endmodule

`default_nettype wire
